### hw/rtl/iqol_pkg.sv
// Package for the input qualifier with output links.
// Holds the shared widths, register and link-mode codes, and the item, result and
// configuration types. Depends on nothing.
`timescale 1ns / 1ps

package iqol_pkg;

	// Defaults for the top-level parameters.
	localparam int CHANNELS_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 12;

	// Number of driven outputs. Link targets at or above it do nothing.
	localparam int OUTPUTS_N = 8;

	// Fixed field widths.
	localparam int CH_W   = 3;
	localparam int SMP_W  = 12;
	localparam int TIME_W = 32;
	localparam int LVL_W  = 8;
	localparam int LINK_W = 3;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	// Link modes, three bits per channel. Codes six and seven do nothing.
	typedef enum logic [LINK_W-1:0] {
		LINK_NONE        = 3'd0,
		LINK_COPY        = 3'd1,
		LINK_NEGATE      = 3'd2,
		LINK_TOGGLE      = 3'd3,
		LINK_TOGGLE_HIGH = 3'd4,
		LINK_TOGGLE_LOW  = 3'd5
	} link_mode_t;

	// Register indexes, at byte address four times the index.
	typedef enum logic [2:0] {
		REG_STABLE_TIME   = 3'd0,
		REG_MIN_VARIATION = 3'd1,
		REG_ANALOG_MASK   = 3'd2,
		REG_LINK_MODES    = 3'd3,
		REG_LINK_TARGETS  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] stable_time;
		logic [SMP_W-1:0]  min_variation;
		logic [7:0]        analog_mask;
		logic [23:0]       link_modes;
		logic [23:0]       link_targets;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [SMP_W-1:0]  sample;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic [CH_W-1:0]   event_channel;
		logic [SMP_W-1:0]  event_value;
		logic [LVL_W-1:0]  output_levels;
		logic              output_changed;
	} result_t;

endpackage

### hw/rtl/iqol_ifs.sv
// Valid/ready channel interfaces for sample items and result events.
// Depends on iqol_pkg for the field widths.
`timescale 1ns / 1ps

interface iqol_item_if;
	import iqol_pkg::*;

	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   channel;
	logic [SMP_W-1:0]  sample;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, channel, sample, now_ms, input ready);
	modport sink   (input valid, channel, sample, now_ms, output ready);
endinterface

interface iqol_event_if;
	import iqol_pkg::*;

	logic              valid;
	logic              ready;
	logic              accepted;
	logic [CH_W-1:0]   event_channel;
	logic [SMP_W-1:0]  event_value;
	logic [LVL_W-1:0]  output_levels;
	logic              output_changed;

	modport source (output valid, accepted, event_channel, event_value, output_levels,
		output_changed, input ready);
	modport sink   (input valid, accepted, event_channel, event_value, output_levels,
		output_changed, output ready);
endinterface

### hw/rtl/iqol_regs.sv
// APB-style configuration registers of the input qualifier.
// Depends on iqol_pkg for the register codes and the configuration struct.
`timescale 1ns / 1ps

module iqol_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [iqol_pkg::ADDR_W-1:0] paddr,
	input  logic [iqol_pkg::DATA_W-1:0] pwdata,
	output logic [iqol_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output iqol_pkg::cfg_t            cfg
);
	import iqol_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; the data is cut to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_STABLE_TIME:   cfg_q.stable_time   <= pwdata;
				REG_MIN_VARIATION: cfg_q.min_variation <= pwdata[SMP_W-1:0];
				REG_ANALOG_MASK:   cfg_q.analog_mask   <= pwdata[7:0];
				REG_LINK_MODES:    cfg_q.link_modes    <= pwdata[23:0];
				REG_LINK_TARGETS:  cfg_q.link_targets  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended.
	always_comb begin
		unique case (idx)
			REG_STABLE_TIME:   prdata = cfg_q.stable_time;
			REG_MIN_VARIATION: prdata = DATA_W'(cfg_q.min_variation);
			REG_ANALOG_MASK:   prdata = DATA_W'(cfg_q.analog_mask);
			REG_LINK_MODES:    prdata = DATA_W'(cfg_q.link_modes);
			REG_LINK_TARGETS:  prdata = DATA_W'(cfg_q.link_targets);
			default:           prdata = '0;
		endcase
	end

endmodule

### hw/rtl/iqol_core.sv
// Per-channel qualifier state, the accept decision and the output link logic.
// Depends on iqol_pkg for the item, result and configuration types.
`timescale 1ns / 1ps

module iqol_core #(
	parameter int CHANNELS    = iqol_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = iqol_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  iqol_pkg::item_t   item,
	input  iqol_pkg::cfg_t    cfg,
	output iqol_pkg::result_t res
);
	import iqol_pkg::*;

	localparam int CMP_W = 16;

	logic [SAMPLE_BITS-1:0] acc_val_q [CHANNELS];
	logic                   has_q     [CHANNELS];
	logic [TIME_W-1:0]      last_q    [CHANNELS];
	logic [LVL_W-1:0]       levels_q;

	logic                   in_range;
	logic [SAMPLE_BITS-1:0] cur_val;
	logic                   cur_has;
	logic [TIME_W-1:0]      cur_last;
	logic                   analog;
	logic [SAMPLE_BITS-1:0] smp_m;
	logic [SAMPLE_BITS-1:0] s;
	logic [SAMPLE_BITS-1:0] diff;
	logic                   same;
	logic                   passes;
	logic                   timed;
	logic [TIME_W-1:0]      elapsed;
	logic                   take;
	logic                   upd_last;
	link_mode_t             mode;
	logic [LINK_W-1:0]      tgt;
	logic [LVL_W-1:0]       bitv;
	logic [LVL_W-1:0]       linked;
	logic [LVL_W-1:0]       lv_next;

	// Pick the state of the addressed channel.
	always_comb begin
		cur_val  = '0;
		cur_has  = 1'b0;
		cur_last = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (int'(item.channel) == i) begin
				cur_val  = acc_val_q[i];
				cur_has  = has_q[i];
				cur_last = last_q[i];
			end
		end
	end

	// Accept decision: a change must clear the deadband and last the stable time.
	always_comb begin
		in_range = int'(item.channel) < CHANNELS;
		analog   = cfg.analog_mask[item.channel];
		smp_m    = SAMPLE_BITS'(item.sample);
		s        = analog ? smp_m : SAMPLE_BITS'(|smp_m);
		same     = cur_has && (cur_val == s);
		diff     = (cur_val > s) ? (cur_val - s) : (s - cur_val);
		passes   = !(cur_has && analog) || (CMP_W'(diff) >= CMP_W'(cfg.min_variation));
		elapsed  = item.now_ms - cur_last;
		timed    = elapsed >= cfg.stable_time;
		take     = in_range && !same && passes && timed;
		upd_last = in_range && (same || !passes || timed);
	end

	// Output link action for an accepted digital change.
	always_comb begin
		mode   = link_mode_t'(cfg.link_modes[LINK_W*item.channel +: LINK_W]);
		tgt    = cfg.link_targets[LINK_W*item.channel +: LINK_W];
		bitv   = LVL_W'(1) << tgt;
		linked = levels_q;
		unique case (mode)
			LINK_COPY:        linked = s[0] ? (levels_q | bitv) : (levels_q & ~bitv);
			LINK_NEGATE:      linked = s[0] ? (levels_q & ~bitv) : (levels_q | bitv);
			LINK_TOGGLE:      linked = levels_q ^ bitv;
			LINK_TOGGLE_HIGH: linked = s[0] ? (levels_q ^ bitv) : levels_q;
			LINK_TOGGLE_LOW:  linked = s[0] ? levels_q : (levels_q ^ bitv);
			default:          linked = levels_q;
		endcase
		lv_next = (take && !analog && (int'(tgt) < OUTPUTS_N)) ? linked : levels_q;
	end

	// Result of the item in the input stage.
	always_comb begin
		res.accepted       = take;
		res.event_channel  = item.channel;
		res.event_value    = in_range ? SMP_W'(take ? s : cur_val) : '0;
		res.output_levels  = lv_next;
		res.output_changed = lv_next != levels_q;
	end

	// State update when the item moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				acc_val_q[i] <= '0;
				has_q[i]     <= 1'b0;
				last_q[i]    <= '0;
			end
			levels_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (int'(item.channel) == i) begin
					if (take) begin
						acc_val_q[i] <= s;
						has_q[i]     <= 1'b1;
					end
					if (upd_last) begin
						last_q[i] <= item.now_ms;
					end
				end
			end
			levels_q <= lv_next;
		end
	end

endmodule

### hw/rtl/input_qualifier_with_output_links_unit.sv
// Top level of the input qualifier with output links.
// Depends on iqol_pkg, iqol_ifs, iqol_regs and iqol_core.
//
// Usage: each transfer on the samples channel carries a channel number, a raw
// sample and the current millisecond time. Every sample gives exactly one
// transfer on the events channel: whether the sample became the channel's new
// accepted value, that value, the levels of the eight linked outputs and
// whether a link action changed them. Configuration goes through the APB port
// while no sample is in flight.
// A sample's transfer loads the input register; the item then moves on to the
// result register, which holds the result that is shown as valid.
// Throughput: one sample per cycle while the receiver takes the results; the
// channel state is read and written as the item moves between the two registers.
// Reset clears all configuration, all channel state and the output levels.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; after that, samples ready drops until the
// result is taken.
`timescale 1ns / 1ps

module input_qualifier_with_output_links_unit #(
	parameter int CHANNELS    = iqol_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = iqol_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	iqol_item_if.sink                   samples,
	iqol_event_if.source                events,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iqol_pkg::ADDR_W-1:0] paddr,
	input  logic [iqol_pkg::DATA_W-1:0] pwdata,
	output logic [iqol_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import iqol_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    in_xfer;

	assign advance       = valid_s1 && (!out_valid_q || events.ready);
	assign samples.ready = !valid_s1 || advance;
	assign in_xfer       = samples.valid && samples.ready;

	iqol_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iqol_core #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.channel <= samples.channel;
			item_s1.sample  <= samples.sample;
			item_s1.now_ms  <= samples.now_ms;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign events.valid          = out_valid_q;
	assign events.accepted       = res_q.accepted;
	assign events.event_channel  = res_q.event_channel;
	assign events.event_value    = res_q.event_value;
	assign events.output_levels  = res_q.output_levels;
	assign events.output_changed = res_q.output_changed;

endmodule
